// ----- rtl/ppcls_pkg.sv -----
// ppcls_pkg: shared constants, codes and structs of the load/store unit core.
// No dependencies; the register file, data memory and core refer to it by scoped names.
package ppcls_pkg;

  localparam int XLEN      = 64;
  localparam int REG_N     = 32;
  localparam int REG_AW    = $clog2(REG_N);
  localparam int MEM_BYTES = 65536;
  localparam int MEM_AW    = $clog2(MEM_BYTES);
  // data memory: two banks of 8-byte rows, even and odd rows
  localparam int ROW_W     = 64;
  localparam int ROW_AW    = MEM_AW - 3;
  localparam int BANK_AW   = MEM_AW - 4;
  localparam int BANK_ROWS = MEM_BYTES / 16;

  localparam logic [3:0] CR0_STCX = 4'd2;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_STORE = 2'd1,
    REQ_STCX  = 2'd2,
    REQ_FENCE = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    SZ_BYTE   = 2'd0,
    SZ_HALF   = 2'd1,
    SZ_WORD   = 2'd2,
    SZ_DOUBLE = 2'd3
  } size_e;

  typedef struct packed {
    logic [REG_AW-1:0] ra;
    logic [REG_AW-1:0] rb;
    logic [REG_AW-1:0] rt;
  } rf_raddr_t;

  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] addr;
    logic [XLEN-1:0]   data;
  } rf_wr_t;

  typedef struct packed {
    logic [XLEN-1:0] ra;
    logic [XLEN-1:0] rb;
    logic [XLEN-1:0] rt_int;
    logic [XLEN-1:0] rt_fp;
  } rf_rdata_t;

  typedef struct packed {
    logic              store_en;
    logic [MEM_AW-1:0] pos;
    size_e             size;
    logic [XLEN-1:0]   data;
  } mem_acc_t;

  typedef struct packed {
    logic               en;
    logic [BANK_AW-1:0] idx;
  } mem_clr_t;

endpackage

// ----- rtl/ppcls_if.sv -----
// ppcls_if: valid/ready channel interfaces of the load/store unit core.
// Request channel carries one decoded access, response channel one result.
interface ppcls_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [1:0]  size_code;
  logic        sign_extend;
  logic        indexed;
  logic        update;
  logic        float_reg;
  logic [4:0]  target_reg;
  logic [4:0]  base_reg;
  logic [4:0]  index_reg;
  logic signed [15:0] displacement;

  modport source (
    output valid, req_type, size_code, sign_extend, indexed, update, float_reg,
           target_reg, base_reg, index_reg, displacement,
    input  ready
  );
  modport sink (
    input  valid, req_type, size_code, sign_extend, indexed, update, float_reg,
           target_reg, base_reg, index_reg, displacement,
    output ready
  );
endinterface

interface ppcls_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] effective_addr;
  logic [63:0] loaded_value;
  logic        cr0_written;
  logic [3:0]  cr0_value;

  modport source (
    output valid, effective_addr, loaded_value, cr0_written, cr0_value,
    input  ready
  );
  modport sink (
    input  valid, effective_addr, loaded_value, cr0_written, cr0_value,
    output ready
  );
endinterface

// ----- rtl/ppcls_ram.sv -----
// ppcls_ram: generic single-write, single-read synchronous RAM.
// Read data is registered, read-first on a same-address write.
module ppcls_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/ppcls_regfile.sv -----
// ppcls_regfile: integer and floating register files on ppcls_ram instances.
// Integer file is kept in three copies (base, index, data reads); a one-entry
// bypass covers a read issued on the same edge as a write. Uses ppcls_pkg.
module ppcls_regfile (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ppcls_pkg::rf_raddr_t raddr_i,
  input  ppcls_pkg::rf_wr_t    int_wr_i,
  input  ppcls_pkg::rf_wr_t    fp_wr_i,
  output ppcls_pkg::rf_rdata_t rdata_o
);

  logic [ppcls_pkg::XLEN-1:0] ra_raw, rb_raw, rt_raw, fp_raw;
  ppcls_pkg::rf_raddr_t       raddr_q;
  ppcls_pkg::rf_wr_t          int_fwd_q, fp_fwd_q;

  ppcls_ram #(.WIDTH(ppcls_pkg::XLEN), .DEPTH(ppcls_pkg::REG_N)) u_int_ra (
    .clk_i, .we_i(int_wr_i.en), .waddr_i(int_wr_i.addr), .wdata_i(int_wr_i.data),
    .raddr_i(raddr_i.ra), .rdata_o(ra_raw)
  );
  ppcls_ram #(.WIDTH(ppcls_pkg::XLEN), .DEPTH(ppcls_pkg::REG_N)) u_int_rb (
    .clk_i, .we_i(int_wr_i.en), .waddr_i(int_wr_i.addr), .wdata_i(int_wr_i.data),
    .raddr_i(raddr_i.rb), .rdata_o(rb_raw)
  );
  ppcls_ram #(.WIDTH(ppcls_pkg::XLEN), .DEPTH(ppcls_pkg::REG_N)) u_int_rt (
    .clk_i, .we_i(int_wr_i.en), .waddr_i(int_wr_i.addr), .wdata_i(int_wr_i.data),
    .raddr_i(raddr_i.rt), .rdata_o(rt_raw)
  );
  ppcls_ram #(.WIDTH(ppcls_pkg::XLEN), .DEPTH(ppcls_pkg::REG_N)) u_fp (
    .clk_i, .we_i(fp_wr_i.en), .waddr_i(fp_wr_i.addr), .wdata_i(fp_wr_i.data),
    .raddr_i(raddr_i.rt), .rdata_o(fp_raw)
  );

  // RAMs read every edge; remember what was read and what was written then
  always_ff @(posedge clk_i) begin
    raddr_q <= raddr_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_fwd_q <= '0;
      fp_fwd_q  <= '0;
    end else begin
      int_fwd_q <= int_wr_i;
      fp_fwd_q  <= fp_wr_i;
    end
  end

  always_comb begin
    rdata_o.ra     = (int_fwd_q.en && int_fwd_q.addr == raddr_q.ra) ? int_fwd_q.data : ra_raw;
    rdata_o.rb     = (int_fwd_q.en && int_fwd_q.addr == raddr_q.rb) ? int_fwd_q.data : rb_raw;
    rdata_o.rt_int = (int_fwd_q.en && int_fwd_q.addr == raddr_q.rt) ? int_fwd_q.data : rt_raw;
    rdata_o.rt_fp  = (fp_fwd_q.en && fp_fwd_q.addr == raddr_q.rt) ? fp_fwd_q.data : fp_raw;
  end

endmodule

// ----- rtl/ppcls_data_mem.sv -----
// ppcls_data_mem: big-endian byte memory as even/odd banks of 8-byte rows.
// An access spans a row and its successor; loads extract, stores merge and
// write both rows back. Uses ppcls_pkg and ppcls_ram.
module ppcls_data_mem (
  input  logic                             clk_i,
  input  logic [ppcls_pkg::MEM_AW-1:0]     rd_addr_i,
  input  ppcls_pkg::mem_acc_t              acc_i,
  input  ppcls_pkg::mem_clr_t              clr_i,
  output logic [ppcls_pkg::XLEN-1:0]       load_raw_o
);

  localparam int RW = ppcls_pkg::ROW_W;

  logic [ppcls_pkg::ROW_AW-1:0]  rd_row, rd_row1, rd_even, rd_odd;
  logic [ppcls_pkg::ROW_AW-1:0]  wr_row, wr_row1, wr_even, wr_odd;
  logic [ppcls_pkg::BANK_AW-1:0] even_waddr, odd_waddr;
  logic [RW-1:0]                 even_q, odd_q, even_wdata, odd_wdata;
  logic                          bank_we;
  logic [2*RW-1:0]               win, win_sh, dwin, mwin, win_new;
  logic [RW-1:0]                 first_row, second_row, top_bytes;
  logic [5:0]                    byte_sh;
  logic [6:0]                    tail_sh;

  // read side: rows for the access now in the address stage
  always_comb begin
    rd_row  = rd_addr_i[ppcls_pkg::MEM_AW-1:3];
    rd_row1 = rd_row + 1'b1;
    rd_even = rd_row[0] ? rd_row1 : rd_row;
    rd_odd  = rd_row[0] ? rd_row : rd_row1;
  end

  // write side: rows for the access in the data stage
  always_comb begin
    wr_row  = acc_i.pos[ppcls_pkg::MEM_AW-1:3];
    wr_row1 = wr_row + 1'b1;
    wr_even = wr_row[0] ? wr_row1 : wr_row;
    wr_odd  = wr_row[0] ? wr_row : wr_row1;
  end

  // window of 16 bytes, lowest address in the top byte
  always_comb begin
    first_row  = wr_row[0] ? odd_q : even_q;
    second_row = wr_row[0] ? even_q : odd_q;
    win        = {first_row, second_row};
    byte_sh    = {acc_i.pos[2:0], 3'b000};
    unique case (acc_i.size)
      ppcls_pkg::SZ_BYTE:   tail_sh = 7'd56;
      ppcls_pkg::SZ_HALF:   tail_sh = 7'd48;
      ppcls_pkg::SZ_WORD:   tail_sh = 7'd32;
      ppcls_pkg::SZ_DOUBLE: tail_sh = 7'd0;
      default:              tail_sh = 7'd0;
    endcase
    win_sh     = win << byte_sh;
    top_bytes  = win_sh[2*RW-1:RW];
    load_raw_o = top_bytes >> tail_sh;

    dwin    = {acc_i.data << tail_sh, {RW{1'b0}}} >> byte_sh;
    mwin    = {{RW{1'b1}} << tail_sh, {RW{1'b0}}} >> byte_sh;
    win_new = (win & ~mwin) | (dwin & mwin);
  end

  always_comb begin
    if (clr_i.en) begin
      bank_we    = 1'b1;
      even_waddr = clr_i.idx;
      odd_waddr  = clr_i.idx;
      even_wdata = '0;
      odd_wdata  = '0;
    end else begin
      bank_we    = acc_i.store_en;
      even_waddr = wr_even[ppcls_pkg::ROW_AW-1:1];
      odd_waddr  = wr_odd[ppcls_pkg::ROW_AW-1:1];
      even_wdata = wr_row[0] ? win_new[RW-1:0] : win_new[2*RW-1:RW];
      odd_wdata  = wr_row[0] ? win_new[2*RW-1:RW] : win_new[RW-1:0];
    end
  end

  ppcls_ram #(.WIDTH(RW), .DEPTH(ppcls_pkg::BANK_ROWS)) u_even (
    .clk_i, .we_i(bank_we), .waddr_i(even_waddr), .wdata_i(even_wdata),
    .raddr_i(rd_even[ppcls_pkg::ROW_AW-1:1]), .rdata_o(even_q)
  );
  ppcls_ram #(.WIDTH(RW), .DEPTH(ppcls_pkg::BANK_ROWS)) u_odd (
    .clk_i, .we_i(bank_we), .waddr_i(odd_waddr), .wdata_i(odd_wdata),
    .raddr_i(rd_odd[ppcls_pkg::ROW_AW-1:1]), .rdata_o(odd_q)
  );

endmodule

// ----- rtl/ppc64_load_store_unit_core.sv -----
// ppc64_load_store_unit_core: PowerPC 64 integer/double-float load/store unit.
// Steps in order: RF read, address add and memory read, memory/RF write-back;
// the result is registered in a result buffer before it can transfer.
// No request is taken while one sits in the address stage (single RF write
// port, bank read-modify-write), nor while the result buffer lacks room.
// Reset: a clearing pass over all MEM_BYTES/16 (4096) rows of each bank zeroes
// memory and registers; no request is taken until it ends.
module ppc64_load_store_unit_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  ppcls_req_if.sink    req_i,
  ppcls_rsp_if.source  rsp_o
);

  typedef struct packed {
    ppcls_pkg::req_type_e              req_type;
    ppcls_pkg::size_e                  size;
    logic                              sext;
    logic                              indexed;
    logic                              update;
    logic                              fp;
    logic [ppcls_pkg::REG_AW-1:0]      rt;
    logic [ppcls_pkg::REG_AW-1:0]      ra;
    logic [15:0]                       disp;
  } op_t;

  typedef struct packed {
    ppcls_pkg::req_type_e              req_type;
    ppcls_pkg::size_e                  size;
    logic                              sext;
    logic                              fp;
    logic [ppcls_pkg::REG_AW-1:0]      rt;
    logic [ppcls_pkg::XLEN-1:0]        ea;
    logic [ppcls_pkg::XLEN-1:0]        sdata;
  } mem_op_t;

  typedef struct packed {
    logic [63:0] ea;
    logic [63:0] loaded;
    logic        cr0_written;
    logic [3:0]  cr0_value;
  } rsp_t;

  logic                           accept, pop;
  logic                           clr_busy_q;
  logic [ppcls_pkg::BANK_AW-1:0]  clr_cnt_q;
  logic                           s1_valid_q, s2_valid_q;
  op_t                            s1_q;
  mem_op_t                        s2_q;
  logic [3:0]                     cond_q, cond_d;

  ppcls_pkg::rf_raddr_t           rf_raddr;
  ppcls_pkg::rf_wr_t              int_wr, fp_wr;
  ppcls_pkg::rf_rdata_t           rf_rdata;
  ppcls_pkg::mem_acc_t            mem_acc;
  ppcls_pkg::mem_clr_t            mem_clr;
  logic [ppcls_pkg::XLEN-1:0]     load_raw, loaded;
  logic [ppcls_pkg::XLEN-1:0]     base, offset, ea;
  logic                           s1_upd, s2_load, s2_store, s2_stcx;

  rsp_t                           fifo_q [2];
  rsp_t                           rsp_new;
  logic [1:0]                     fifo_cnt_q, occ;
  logic                           wr_ptr_q, rd_ptr_q;

  // ---------------- handshake ----------------
  assign occ          = fifo_cnt_q + {1'b0, s2_valid_q};
  assign req_i.ready  = !clr_busy_q && !s1_valid_q && (occ < 2'd2);
  assign accept       = req_i.valid && req_i.ready;
  assign pop          = rsp_o.valid && rsp_o.ready;

  // ---------------- clearing pass ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == ppcls_pkg::BANK_AW'(ppcls_pkg::BANK_ROWS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // ---------------- stage 1: register read, address ----------------
  assign rf_raddr.ra = req_i.base_reg;
  assign rf_raddr.rb = req_i.index_reg;
  assign rf_raddr.rt = req_i.target_reg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.req_type <= ppcls_pkg::req_type_e'(req_i.req_type);
      s1_q.size     <= ppcls_pkg::size_e'(req_i.size_code);
      s1_q.sext     <= req_i.sign_extend;
      s1_q.indexed  <= req_i.indexed;
      s1_q.update   <= req_i.update;
      s1_q.fp       <= req_i.float_reg;
      s1_q.rt       <= req_i.target_reg;
      s1_q.ra       <= req_i.base_reg;
      s1_q.disp     <= req_i.displacement;
    end
  end

  always_comb begin
    base   = (s1_q.ra != '0 || s1_q.update) ? rf_rdata.ra : '0;
    offset = s1_q.indexed ? rf_rdata.rb : {{48{s1_q.disp[15]}}, s1_q.disp};
    ea     = base + offset;
    s1_upd = s1_valid_q && s1_q.update && (s1_q.req_type != ppcls_pkg::REQ_FENCE);
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_q.req_type <= s1_q.req_type;
      s2_q.size     <= s1_q.size;
      s2_q.sext     <= s1_q.sext;
      s2_q.fp       <= s1_q.fp;
      s2_q.rt       <= s1_q.rt;
      s2_q.ea       <= (s1_q.req_type == ppcls_pkg::REQ_FENCE) ? '0 : ea;
      s2_q.sdata    <= s1_q.fp ? rf_rdata.rt_fp : rf_rdata.rt_int;
    end
  end

  // ---------------- stage 2: memory data, write-back ----------------
  assign s2_load  = s2_valid_q && (s2_q.req_type == ppcls_pkg::REQ_LOAD);
  assign s2_stcx  = s2_valid_q && (s2_q.req_type == ppcls_pkg::REQ_STCX);
  assign s2_store = s2_valid_q && ((s2_q.req_type == ppcls_pkg::REQ_STORE) ||
                                   (s2_q.req_type == ppcls_pkg::REQ_STCX));

  always_comb begin
    unique case (s2_q.size)
      ppcls_pkg::SZ_BYTE:
        loaded = {{56{s2_q.sext & load_raw[7]}}, load_raw[7:0]};
      ppcls_pkg::SZ_HALF:
        loaded = {{48{s2_q.sext & load_raw[15]}}, load_raw[15:0]};
      ppcls_pkg::SZ_WORD:
        loaded = {{32{s2_q.sext & load_raw[31]}}, load_raw[31:0]};
      ppcls_pkg::SZ_DOUBLE:
        loaded = load_raw;
      default:
        loaded = load_raw;
    endcase
  end

  assign mem_acc.store_en = s2_store;
  assign mem_acc.pos      = s2_q.ea[ppcls_pkg::MEM_AW-1:0];
  assign mem_acc.size     = s2_q.size;
  assign mem_acc.data     = s2_q.sdata;
  assign mem_clr.en       = clr_busy_q;
  assign mem_clr.idx      = clr_cnt_q;

  // one integer write a cycle: address update in stage 1, load in stage 2
  always_comb begin
    priority if (clr_busy_q) begin
      int_wr = '{en: 1'b1, addr: clr_cnt_q[ppcls_pkg::REG_AW-1:0], data: '0};
    end else if (s1_upd) begin
      int_wr = '{en: 1'b1, addr: s1_q.ra, data: ea};
    end else if (s2_load && !s2_q.fp) begin
      int_wr = '{en: 1'b1, addr: s2_q.rt, data: loaded};
    end else begin
      int_wr = '{en: 1'b0, addr: s2_q.rt, data: loaded};
    end
    priority if (clr_busy_q) begin
      fp_wr = '{en: 1'b1, addr: clr_cnt_q[ppcls_pkg::REG_AW-1:0], data: '0};
    end else begin
      fp_wr = '{en: s2_load && s2_q.fp, addr: s2_q.rt, data: loaded};
    end
  end

  assign cond_d = s2_stcx ? ppcls_pkg::CR0_STCX : cond_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cond_q <= '0;
    end else begin
      cond_q <= cond_d;
    end
  end

  ppcls_regfile u_regfile (
    .clk_i,
    .rst_ni,
    .raddr_i  (rf_raddr),
    .int_wr_i (int_wr),
    .fp_wr_i  (fp_wr),
    .rdata_o  (rf_rdata)
  );

  ppcls_data_mem u_data_mem (
    .clk_i,
    .rd_addr_i  (ea[ppcls_pkg::MEM_AW-1:0]),
    .acc_i      (mem_acc),
    .clr_i      (mem_clr),
    .load_raw_o (load_raw)
  );

  // ---------------- result buffer ----------------
  always_comb begin
    rsp_new.ea          = s2_q.ea;
    rsp_new.loaded      = s2_load ? loaded : '0;
    rsp_new.cr0_written = s2_stcx;
    rsp_new.cr0_value   = cond_d;
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      fifo_q[wr_ptr_q] <= rsp_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fifo_cnt_q <= '0;
      wr_ptr_q   <= 1'b0;
      rd_ptr_q   <= 1'b0;
    end else begin
      if (s2_valid_q) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      fifo_cnt_q <= fifo_cnt_q + {1'b0, s2_valid_q} - {1'b0, pop};
    end
  end

  assign rsp_o.valid          = (fifo_cnt_q != '0);
  assign rsp_o.effective_addr = fifo_q[rd_ptr_q].ea;
  assign rsp_o.loaded_value   = fifo_q[rd_ptr_q].loaded;
  assign rsp_o.cr0_written    = fifo_q[rd_ptr_q].cr0_written;
  assign rsp_o.cr0_value      = fifo_q[rd_ptr_q].cr0_value;

`ifndef NO_ASSERTIONS
  // address and data stages never hold items at once: one RF write port suffices
  a_stage_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_valid_q && s2_valid_q))
    else $error("address and data stages both occupied");

  // in-flight items never exceed the result buffer
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, fifo_cnt_q} + {2'b0, s1_valid_q} + {2'b0, s2_valid_q}) <= 3'd2)
    else $error("result buffer overcommitted");

  // nothing taken during the clearing pass
  a_clr_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !req_i.ready)
    else $error("request taken during memory clear");

  // an accepted request passes the address stage and then reaches the data stage
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 s2_valid_q)
    else $error("accepted request lost in pipeline");
`endif

endmodule
